[src/kpc_pkg.sv]
// Shared types and constants for the key press classifier.
// No dependencies; imported by key_press_classifier.
`default_nettype none

package kpc_pkg;

    typedef logic [2:0] t_class;

    // Class codes seen on the result channel.
    localparam t_class CLASS_IDLE       = 3'd0;
    localparam t_class CLASS_COLLECTING = 3'd1;
    localparam t_class CLASS_SINGLE     = 3'd2;
    localparam t_class CLASS_DOUBLE     = 3'd3;
    localparam t_class CLASS_LONG       = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_TICK_PERIOD     = 3'd0;
    localparam logic [2:0] REG_GAP_TIMEOUT     = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS_TIME = 3'd2;
    localparam logic [2:0] REG_MIN_CLICK_TIME  = 3'd3;
    localparam logic [2:0] REG_MAX_CLICK_TIME  = 3'd4;

    localparam int CFG_DATA_W = 12;

    // Released time saturates here.
    localparam logic [8:0] RELEASED_MAX = 9'd511;

endpackage

`default_nettype wire

[src/key_press_classifier.sv]
// Single, double and long press detector: one key sample in, one class out per beat.
// Depends on kpc_pkg for class codes and register indexes.
`default_nettype none

// The block takes one sampled key level per input beat and returns one class per beat,
// at a sustained rate of one beat per clock cycle while o_stall is low. The classifier
// state is updated in the cycle the beat is accepted and its class is registered into
// the output buffer. A two-entry output buffer (output register plus skid register)
// lets the input keep flowing while the output is stalled until the skid entry fills;
// o_stall rises only when both entries are full. The configuration port is always
// ready and its writes take effect on the next input beat.
module key_press_classifier
    import kpc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // Input channel
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire                   i_key_down,
    // Result channel
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [2:0]            o_click_class,
    // Configuration write channel
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [2:0]            i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [7:0]  r_tick_period;
    logic [7:0]  r_gap_timeout;
    logic [11:0] r_long_press_time;
    logic [11:0] r_min_click_time;
    logic [11:0] r_max_click_time;

    // Classifier state
    logic        r_prev_level,    n_prev_level;
    logic [11:0] r_held_time,     n_held_time;
    logic [8:0]  r_released_time, n_released_time;
    logic [1:0]  r_click_count,   n_click_count;
    t_class      r_class,         n_class;

    // Output buffer
    logic        r_out_valid,  r_skid_valid;
    t_class      r_out_class,  r_skid_class;

    logic        w_in_accept;
    logic        w_out_pop;
    logic        w_cfg_write;
    logic [9:0]  w_rel_sum;
    logic [8:0]  w_rel_sat;
    logic [12:0] w_held_sum;
    t_class      w_class_mid;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;

    assign o_stall     = r_skid_valid;
    assign w_in_accept = i_valid & ~r_skid_valid;
    assign w_out_pop   = r_out_valid & ~i_stall;

    assign o_valid       = r_out_valid;
    assign o_click_class = r_out_class;

    assign w_rel_sum  = {1'b0, r_released_time} + {2'b00, r_tick_period};
    assign w_rel_sat  = (w_rel_sum > {1'b0, RELEASED_MAX}) ? RELEASED_MAX : w_rel_sum[8:0];
    assign w_held_sum = {1'b0, r_held_time} + {5'b00000, r_tick_period};

    always_comb begin
        n_prev_level    = r_prev_level;
        n_held_time     = r_held_time;
        n_released_time = r_released_time;
        n_click_count   = r_click_count;
        n_class         = r_class;
        // A press edge restarts collection before the per-level update.
        w_class_mid = (!r_prev_level && i_key_down) ? CLASS_COLLECTING : r_class;
        if (w_in_accept) begin
            n_prev_level = i_key_down;
            n_class      = w_class_mid;
            if (w_class_mid == CLASS_COLLECTING) begin
                case ({r_prev_level, i_key_down})
                    2'b00: begin
                        if (w_rel_sat >= {1'b0, r_gap_timeout}) begin
                            n_released_time = '0;
                            n_held_time     = '0;
                            if (r_click_count == 2'd1) begin
                                n_class = CLASS_SINGLE;
                            end else if (r_click_count == 2'd2) begin
                                n_class = CLASS_DOUBLE;
                            end
                            n_click_count = '0;
                        end else begin
                            n_released_time = w_rel_sat;
                        end
                    end
                    2'b01: begin
                        n_held_time = '0;
                    end
                    2'b11: begin
                        if (w_held_sum >= {1'b0, r_long_press_time}) begin
                            n_held_time = r_long_press_time;
                            n_class     = CLASS_LONG;
                        end else begin
                            n_held_time = w_held_sum[11:0];
                        end
                    end
                    default: begin
                        // Release: a press of valid length counts a click.
                        if (r_held_time > r_min_click_time && r_held_time < r_max_click_time
                            && r_click_count != 2'd3) begin
                            n_click_count = r_click_count + 2'd1;
                        end
                        n_released_time = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level    <= 1'b1;
            r_held_time     <= '0;
            r_released_time <= '0;
            r_click_count   <= '0;
            r_class         <= CLASS_IDLE;
        end else begin
            r_prev_level    <= n_prev_level;
            r_held_time     <= n_held_time;
            r_released_time <= n_released_time;
            r_click_count   <= n_click_count;
            r_class         <= n_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period     <= 8'd10;
            r_gap_timeout     <= 8'd200;
            r_long_press_time <= 12'd2000;
            r_min_click_time  <= 12'd30;
            r_max_click_time  <= 12'd1000;
        end else if (w_cfg_write) begin
            case (i_cfg_index)
                REG_TICK_PERIOD:     r_tick_period     <= i_cfg_data[7:0];
                REG_GAP_TIMEOUT:     r_gap_timeout     <= i_cfg_data[7:0];
                REG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                REG_MIN_CLICK_TIME:  r_min_click_time  <= i_cfg_data;
                REG_MAX_CLICK_TIME:  r_max_click_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Two-entry output buffer; the skid entry only fills while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_in_accept;
                end
            end else if (w_in_accept) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_pop) begin
            r_out_class <= r_skid_valid ? r_skid_class : n_class;
        end else if (w_in_accept) begin
            if (!r_out_valid) begin
                r_out_class <= n_class;
            end else begin
                r_skid_class <= n_class;
            end
        end
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for key_press_classifier: a short directed table, then
// random click sequences under several register settings and idle patterns.
// Depends on kpc_pkg and the key_press_classifier RTL.
`timescale 1ns / 1ps

module tb_top;
    import kpc_pkg::*;

    typedef enum logic {ROW_KEY, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  key;
        logic [2:0]            idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    known;
        t_class                cls;
    } t_stim_row;

    // Highest index of the register port; the ones above the last real register are unused.
    localparam logic [2:0] REG_INDEX_LAST = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_key_down = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [2:0]            o_click_class;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [2:0]            i_cfg_index = REG_TICK_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Classifier shadow: register copies and state.
    logic [7:0]  cfg_tick = 8'd10;
    logic [7:0]  cfg_gap = 8'd200;
    logic [11:0] cfg_long = 12'd2000;
    logic [11:0] cfg_min = 12'd30;
    logic [11:0] cfg_max = 12'd1000;
    logic        prev_level = 1'b1;
    logic [11:0] held_time = '0;
    logic [8:0]  released_time = '0;
    logic [1:0]  click_count = '0;
    t_class      class_state = CLASS_IDLE;

    t_class      expected_classes[$];
    t_stim_row   stim_table[$];
    int          mismatches = 0;
    int          keys_sent = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    key_press_classifier uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_key_down    (i_key_down),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_click_class (o_click_class),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_class want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_classes.size() == 0) begin
                mismatches++;
                $display("%0t: class beat with none expected: expected none, actual %0d",
                         $time, o_click_class);
            end else begin
                want = expected_classes.pop_front();
                if (o_click_class !== want) begin
                    mismatches++;
                    $display("%0t: click_class mismatch: expected %0d, actual %0d",
                             $time, want, o_click_class);
                end
            end
        end
    end

    // Advances the shadow classifier by one key sample and returns the class it shows.
    function automatic t_class classify_key(input logic level);
        logic prev;
        int   rsum;
        int   hsum;
        prev = prev_level;
        if (!prev && level)
            class_state = CLASS_COLLECTING;
        prev_level = level;
        if (class_state == CLASS_COLLECTING) begin
            if (!prev && !level) begin
                rsum = released_time + cfg_tick;
                if (rsum > RELEASED_MAX)
                    rsum = RELEASED_MAX;
                if (rsum >= cfg_gap) begin
                    released_time = '0;
                    held_time = '0;
                    if (click_count == 2'd1)
                        class_state = CLASS_SINGLE;
                    else if (click_count == 2'd2)
                        class_state = CLASS_DOUBLE;
                    click_count = '0;
                end else begin
                    released_time = rsum[8:0];
                end
            end else if (!prev && level) begin
                held_time = '0;
            end else if (prev && level) begin
                hsum = held_time + cfg_tick;
                if (hsum >= cfg_long) begin
                    held_time = cfg_long;
                    class_state = CLASS_LONG;
                end else begin
                    held_time = hsum[11:0];
                end
            end else begin
                // Release: the press counts as a click only if strictly inside the window.
                if (held_time > cfg_min && held_time < cfg_max && click_count != 2'd3)
                    click_count++;
                released_time = '0;
            end
        end
        return class_state;
    endfunction

    function automatic t_stim_row key_row(input logic key, input bit known, input t_class cls);
        t_stim_row row;
        row = '{ROW_KEY, key, REG_TICK_PERIOD, '0, known, cls};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [2:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '{ROW_CFG, 1'b0, idx, data, 1'b0, CLASS_IDLE};
        return row;
    endfunction

    // Sends one key beat; a typed class, when given, replaces the shadow's answer.
    task automatic drive_key(input logic level, input bit known, input t_class typed);
        t_class predicted;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key_down <= level;
        do @(posedge i_clk); while (o_stall);
        predicted = classify_key(level);
        expected_classes.push_back(known ? typed : predicted);
        keys_sent++;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TICK_PERIOD:     cfg_tick = data[7:0];
            REG_GAP_TIMEOUT:     cfg_gap = data[7:0];
            REG_LONG_PRESS_TIME: cfg_long = data;
            REG_MIN_CLICK_TIME:  cfg_min = data;
            REG_MAX_CLICK_TIME:  cfg_max = data;
            default: ;
        endcase
    endtask

    task automatic write_thresholds(input logic [CFG_DATA_W-1:0] tick,
                                    input logic [CFG_DATA_W-1:0] gap,
                                    input logic [CFG_DATA_W-1:0] long_time,
                                    input logic [CFG_DATA_W-1:0] min_time,
                                    input logic [CFG_DATA_W-1:0] max_time);
        cfg_write(REG_TICK_PERIOD, tick);
        cfg_write(REG_GAP_TIMEOUT, gap);
        cfg_write(REG_LONG_PRESS_TIME, long_time);
        cfg_write(REG_MIN_CLICK_TIME, min_time);
        cfg_write(REG_MAX_CLICK_TIME, max_time);
    endtask

    // Drops both valids and waits until every expected class has come back.
    task automatic settle();
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (expected_classes.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Number of ticks needed to cross a threshold, kept short so sequences stay brief.
    function automatic int ticks_for(input int threshold);
        int n;
        if (cfg_tick == 0)
            return 3;
        n = threshold / cfg_tick + 2;
        return (n > 40) ? 40 : n;
    endfunction

    task automatic press_release(input int hold_ticks, input int gap_ticks);
        repeat (hold_ticks + 1) drive_key(1'b1, 1'b0, CLASS_IDLE);
        repeat (gap_ticks + 1) drive_key(1'b0, 1'b0, CLASS_IDLE);
    endtask

    // Mostly click sequences sized to the current thresholds, with some noise beats.
    task automatic run_phase(input int count);
        int stop;
        int presses;
        int hold_lim;
        int long_lim;
        int gap_lim;
        stop = keys_sent + count;
        hold_lim = ticks_for(cfg_max);
        long_lim = ticks_for(cfg_long);
        gap_lim = ticks_for(cfg_gap);
        while (keys_sent < stop) begin
            if ($urandom_range(7) == 0) begin
                drive_key(1'($urandom_range(1)), 1'b0, CLASS_IDLE);
            end else begin
                presses = $urandom_range(1, 4);
                for (int c = 0; c < presses; c++)
                    press_release(($urandom_range(3) == 0) ? $urandom_range(0, long_lim)
                                                           : $urandom_range(0, hold_lim),
                                  (c == presses - 1) ? gap_lim : $urandom_range(0, gap_lim));
            end
        end
    endtask

    initial begin : stimulus
        int tick;
        int min_time;
        t_stim_row row;

        // A key held through reset gives no press edge.
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_IDLE));
        stim_table.push_back(key_row(1'b0, 1'b1, CLASS_IDLE));
        stim_table.push_back(cfg_row(REG_TICK_PERIOD, 12'd255));
        stim_table.push_back(cfg_row(REG_GAP_TIMEOUT, 12'd255));
        // Two clicks, then the gap runs out.
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_COLLECTING));
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_COLLECTING));
        stim_table.push_back(key_row(1'b0, 1'b1, CLASS_COLLECTING));
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_COLLECTING));
        stim_table.push_back(key_row(1'b1, 1'b0, CLASS_IDLE));
        stim_table.push_back(key_row(1'b0, 1'b0, CLASS_IDLE));
        stim_table.push_back(key_row(1'b0, 1'b1, CLASS_DOUBLE));
        // One click.
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_COLLECTING));
        stim_table.push_back(key_row(1'b1, 1'b0, CLASS_IDLE));
        stim_table.push_back(key_row(1'b0, 1'b0, CLASS_IDLE));
        stim_table.push_back(key_row(1'b0, 1'b1, CLASS_SINGLE));
        // Three clicks: the timeout clears the count and the class stays collecting.
        repeat (3) begin
            stim_table.push_back(key_row(1'b1, 1'b0, CLASS_IDLE));
            stim_table.push_back(key_row(1'b1, 1'b0, CLASS_IDLE));
            stim_table.push_back(key_row(1'b0, 1'b0, CLASS_IDLE));
        end
        stim_table.push_back(key_row(1'b0, 1'b1, CLASS_COLLECTING));
        // A zero long threshold declares a long press on the first held tick.
        stim_table.push_back(cfg_row(REG_LONG_PRESS_TIME, 12'd0));
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_COLLECTING));
        stim_table.push_back(key_row(1'b1, 1'b1, CLASS_LONG));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_CFG) begin
                settle();
                cfg_write(row.idx, row.data);
            end else begin
                drive_key(row.key, row.known, row.cls);
            end
        end

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            settle();
            case (p)
                0: write_thresholds(12'd10, 12'd200, 12'd2000, 12'd30, 12'd1000);
                1: write_thresholds(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
                2: write_thresholds(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
                default: begin
                    // Upper data bits on the 8-bit registers must be dropped.
                    tick = $urandom_range(1, 64);
                    min_time = tick * $urandom_range(0, 5);
                    write_thresholds({4'($urandom), 8'(tick)},
                                     {4'($urandom), 8'($urandom_range(1, 255))},
                                     12'(tick * $urandom_range(2, 30)),
                                     12'(min_time),
                                     12'(min_time + tick * $urandom_range(1, 10)));
                    cfg_write(3'($urandom_range(REG_MAX_CLICK_TIME + 1, REG_INDEX_LAST)),
                              12'($urandom));
                end
            endcase
            run_phase(40);
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[key_press_classifier.f]
src/kpc_pkg.sv
src/key_press_classifier.sv
dv/tb_top.sv
